// ===== hw/rtl/tpsg_pkg.sv =====
// Shared types and constants for the touch pad slider gesture block.
// Used by the front end, the word queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tpsg_pkg;

	localparam int NUM_PADS        = 3;
	localparam int NUM_SLOTS       = 2 * NUM_PADS;
	localparam int TAP_LIMIT_RESET = 200;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;

	typedef enum logic [1:0] {
		MODE_BUTTON = 2'd0,
		MODE_SLIDER = 2'd1,
		MODE_MIX    = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE       = 2'd0,
		CFG_INVERT     = 2'd1,
		CFG_TAP_LIMIT  = 2'd2
	} cfg_index_t;

	localparam logic KIND_KEY    = 1'b0;
	localparam logic KIND_SLIDER = 1'b1;

	// One queued word: either one slider move or a set of key slots.
	// Slots 0..2 come before slots 3..5; slot s refers to pad s mod 3.
	typedef struct packed {
		logic                  slide;
		logic [NUM_SLOTS-1:0]  mask;
		logic [NUM_SLOTS-1:0]  press;
		logic signed [3:0]     dpos;
		logic [31:0]           dt;
	} tpsg_entry_t;

	function automatic logic [2:0] pos_of_pattern(input logic [2:0] pat);
		logic [2:0] pos;
		unique case (pat)
			3'd0: pos = 3'd0;
			3'd1: pos = 3'd1;
			3'd2: pos = 3'd3;
			3'd3: pos = 3'd2;
			3'd4: pos = 3'd5;
			3'd5: pos = 3'd0;
			3'd6: pos = 3'd4;
			default: pos = 3'd0;
		endcase
		return pos;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tpsg_front.sv =====
// Front end: configuration registers, gesture state and event classification.
// Depends on tpsg_pkg; emits one queue word per event that yields results.
`timescale 1ns / 1ps
`default_nettype none

module tpsg_front #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [tpsg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tpsg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              accept,
	input  wire logic [2:0]                        first_status,
	input  wire logic [2:0]                        second_status,
	input  wire logic [31:0]                       now_ms,
	output tpsg_pkg::tpsg_entry_t                  entry,
	output logic                                   push
);

	logic [1:0]            mode_q;
	logic                  invert_q;
	logic [15:0]           tap_limit_q;

	logic [2:0]            last_status_q;
	logic [2:0]            prev_position_q;
	logic [TIME_BITS-1:0]  prev_time_q;
	logic [TIME_BITS-1:0]  cycle_start_q;
	logic [2:0]            gathered_q;
	logic                  sliding_q;

	logic [63:0]           now_w;
	logic [TIME_BITS-1:0]  now_t;
	logic [TIME_BITS-1:0]  dt_t;
	logic [63:0]           dt_w;
	logic [TIME_BITS-1:0]  dur;
	logic [63:0]           tap_w;
	logic [TIME_BITS-1:0]  start_n;
	logic                  button;
	logic                  mix;
	logic [2:0]            pos;
	logic signed [3:0]     dpos;
	logic                  moved;
	logic                  tap;
	logic [2:0]            gathered_n;

	assign now_w   = {32'd0, now_ms};
	assign now_t   = now_w[TIME_BITS-1:0];
	assign tap_w   = {48'd0, tap_limit_q};
	assign button  = (mode_q == tpsg_pkg::MODE_BUTTON);
	assign mix     = mode_q[1];
	assign start_n = (mix && last_status_q == 3'd0) ? now_t : cycle_start_q;
	assign dt_t    = now_t - prev_time_q;
	assign dt_w    = 64'(dt_t);
	assign dur     = now_t - start_n;
	assign pos     = tpsg_pkg::pos_of_pattern(second_status);
	assign dpos    = $signed({1'b0, pos}) - $signed({1'b0, prev_position_q});
	assign moved   = !button && second_status != 3'd0 && last_status_q != 3'd0
		&& dpos != 4'sd0;
	assign gathered_n = (mix && second_status != 3'd0) ? (gathered_q | second_status)
		: gathered_q;
	assign tap = !button && mix && second_status == 3'd0 && !sliding_q
		&& dur <= tap_w[TIME_BITS-1:0];

	always_comb begin
		entry = '0;
		entry.slide = moved;
		entry.dpos  = invert_q ? -dpos : dpos;
		entry.dt    = dt_w[31:0];
		if (button) begin
			entry.mask  = {first_status ^ second_status, last_status_q ^ first_status};
			entry.press = {second_status, first_status};
		end else if (tap) begin
			entry.mask  = {gathered_n, gathered_n};
			entry.press = {3'b000, 3'b111};
		end
		push = accept && (entry.slide || entry.mask != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= tpsg_pkg::MODE_BUTTON;
			invert_q    <= 1'b0;
			tap_limit_q <= 16'(tpsg_pkg::TAP_LIMIT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				tpsg_pkg::CFG_MODE:      mode_q      <= cfg_data[1:0];
				tpsg_pkg::CFG_INVERT:    invert_q    <= cfg_data[0];
				tpsg_pkg::CFG_TAP_LIMIT: tap_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_status_q   <= '0;
			prev_position_q <= '0;
			prev_time_q     <= '0;
			cycle_start_q   <= '0;
			gathered_q      <= '0;
			sliding_q       <= 1'b0;
		end else if (accept) begin
			last_status_q <= second_status;
			if (!button) begin
				cycle_start_q   <= start_n;
				prev_time_q     <= now_t;
				prev_position_q <= (second_status == 3'd0) ? 3'd0 : pos;
				if (second_status == 3'd0) begin
					if (mix) begin
						gathered_q <= '0;
						sliding_q  <= 1'b0;
					end
				end else begin
					gathered_q <= gathered_n;
					if (mix && moved)
						sliding_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tpsg_queue.sv =====
// Short word queue between the front end and the back end.
// Depends on tpsg_pkg for the word type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tpsg_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire tpsg_pkg::tpsg_entry_t  wr_data,
	input  wire logic                   pop,
	output tpsg_pkg::tpsg_entry_t       rd_data,
	output logic                        not_empty,
	output logic                        full
);

	tpsg_pkg::tpsg_entry_t                 mem [tpsg_pkg::QUEUE_DEPTH];
	logic [tpsg_pkg::QPTR_W-1:0]           wr_ptr_q;
	logic [tpsg_pkg::QPTR_W-1:0]           rd_ptr_q;
	logic [tpsg_pkg::QCNT_W-1:0]           count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == tpsg_pkg::QCNT_W'(tpsg_pkg::QUEUE_DEPTH));
	assign rd_data   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tpsg_back.sv =====
// Back end: expands one queued word into result words, one per cycle while out_stall is low.
// Depends on tpsg_pkg for the word type and result codes.
`timescale 1ns / 1ps
`default_nettype none

module tpsg_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tpsg_pkg::tpsg_entry_t  q_data,
	input  wire logic                   q_not_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        kind,
	output logic [1:0]                  pad,
	output logic                        is_press,
	output logic signed [3:0]           pos_change,
	output logic [31:0]                 elapsed_ms,
	output logic                        last
);

	tpsg_pkg::tpsg_entry_t           cur_q;
	logic                            busy_q;
	logic [2:0]                      slot;
	logic [tpsg_pkg::NUM_SLOTS-1:0]  rest;
	logic                            done;
	logic                            taken;

	always_comb begin
		slot = '0;
		for (int i = tpsg_pkg::NUM_SLOTS - 1; i >= 0; i--)
			if (cur_q.mask[i])
				slot = 3'(i);
	end

	assign rest  = cur_q.mask & (cur_q.mask - 1'b1);
	assign done  = cur_q.slide || rest == '0;
	assign taken = busy_q && !out_stall;
	assign pop   = q_not_empty && (!busy_q || (taken && done));

	assign out_valid      = busy_q;
	assign kind           = cur_q.slide ? tpsg_pkg::KIND_SLIDER : tpsg_pkg::KIND_KEY;
	assign pad            = cur_q.slide ? 2'd0
		: (slot >= 3'd3 ? 2'(slot - 3'd3) : slot[1:0]);
	assign is_press       = !cur_q.slide && cur_q.press[slot];
	assign pos_change     = cur_q.slide ? cur_q.dpos : 4'sd0;
	assign elapsed_ms     = cur_q.slide ? cur_q.dt : 32'd0;
	assign last           = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cur_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cur_q  <= q_data;
		end else if (taken) begin
			if (done)
				busy_q <= 1'b0;
			else
				cur_q.mask <= rest;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/touch_pad_slider_gesture.sv =====
// Touch pad slider gesture decoder, top level: front end, word queue, back end.
// Path: with the back end idle, an accepted event is written into the word queue and then
// loaded into the back end's current-word register, which drives its first result.
// Throughput: one event per cycle while the four-word queue has room; each event
// yields zero to six results on the output.
// Reset: asynchronous, clears all gesture state, mode 0, no inversion, tap limit 200.
`timescale 1ns / 1ps
`default_nettype none

module touch_pad_slider_gesture #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [tpsg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tpsg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [2:0]                        first_status,
	input  wire logic [2:0]                        second_status,
	input  wire logic [31:0]                       now_ms,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   kind,
	output logic [1:0]                             pad,
	output logic                                   is_press,
	output logic signed [3:0]                      pos_change,
	output logic [31:0]                            elapsed_ms,
	output logic                                   last
);

	tpsg_pkg::tpsg_entry_t  fr_entry;
	tpsg_pkg::tpsg_entry_t  q_data;
	logic                   push;
	logic                   pop;
	logic                   q_not_empty;
	logic                   q_full;
	logic                   accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	tpsg_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.first_status (first_status),
		.second_status(second_status),
		.now_ms       (now_ms),
		.entry        (fr_entry),
		.push         (push)
	);

	tpsg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (fr_entry),
		.pop      (pop),
		.rd_data  (q_data),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	tpsg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_data        (q_data),
		.q_not_empty   (q_not_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.pad           (pad),
		.is_press      (is_press),
		.pos_change    (pos_change),
		.elapsed_ms    (elapsed_ms),
		.last          (last)
	);

endmodule

`default_nettype wire
